@@ rtl/core/plwu_pkg.sv @@
// ----------------------------------------------------------------------------
// plwu_pkg
// Shared types, constants and tables of the landmark weight update block.
// ----------------------------------------------------------------------------
`default_nettype none

package plwu_pkg;

  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned CW_BITS       = 34;

  localparam logic [31:0] ONE_Q24   = 32'd16777216;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;
  localparam logic [30:0] EXP_CAP   = 31'd1073741824;
  localparam logic [23:0] LN2_Q24   = 24'd11629080;
  localparam logic [8:0]  RECIP_LN2 = 9'd369;
  localparam logic signed [CW_BITS-1:0] CORDIC_K = 34'sd652032874;

  localparam logic [2:0] REG_GATE_RANGE     = 3'd0;
  localparam logic [2:0] REG_INV_TWO_VAR_X  = 3'd1;
  localparam logic [2:0] REG_INV_TWO_VAR_Y  = 3'd2;
  localparam logic [2:0] REG_NORM_FACTOR    = 3'd3;
  localparam logic [2:0] REG_LANDMARK_COUNT = 3'd4;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_OBSERVE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         slot;
    logic [15:0]        landmark_id;
    logic signed [31:0] landmark_x;
    logic signed [31:0] landmark_y;
    logic signed [31:0] particle_x;
    logic signed [31:0] particle_y;
    logic [15:0]        particle_heading;
    logic signed [31:0] obs_x;
    logic signed [31:0] obs_y;
    logic               first_observation;
  } plwu_in_t;

  typedef struct packed {
    logic signed [31:0] map_x;
    logic signed [31:0] map_y;
    logic [15:0]        matched_id;
    logic               found;
    logic [31:0]        obs_likelihood;
    logic [31:0]        particle_weight;
  } plwu_out_t;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } lm_entry_t;

  typedef struct packed {
    logic        found;
    logic [15:0] id;
    logic [63:0] sqx;
    logic [63:0] sqy;
  } plwu_match_t;

  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517D;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // floor(2^32 / n) for the Horner divisors
  function automatic logic [32:0] recip_n(input logic [3:0] n);
    logic [32:0] r;
    case (n)
      4'd1: r = 33'h100000000;
      4'd2: r = 33'h080000000;
      4'd3: r = 33'd1431655765;
      4'd4: r = 33'h040000000;
      4'd5: r = 33'd858993459;
      4'd6: r = 33'd715827882;
      4'd7: r = 33'd613566756;
      4'd8: r = 33'h020000000;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/plwu_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// plwu_cordic_cell
// One rotation stage of the heading CORDIC chain, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module plwu_cordic_cell
  import plwu_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic signed [CW_BITS-1:0] in_x,
  input  wire logic signed [CW_BITS-1:0] in_y,
  input  wire logic signed [CW_BITS-1:0] in_z,
  output logic                           out_valid,
  output logic signed [CW_BITS-1:0]      out_x,
  output logic signed [CW_BITS-1:0]      out_y,
  output logic signed [CW_BITS-1:0]      out_z
);

  localparam logic signed [CW_BITS-1:0] ANGLE = CW_BITS'(atan_turn(STAGE));

  logic signed [CW_BITS-1:0] xs, ys;

  assign xs = in_x >>> STAGE;
  assign ys = in_y >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_z[CW_BITS-1]) begin
      out_x <= in_x - ys;
      out_y <= in_y + xs;
      out_z <= in_z - ANGLE;
    end else begin
      out_x <= in_x + ys;
      out_y <= in_y - xs;
      out_z <= in_z + ANGLE;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/plwu_search.sv @@
// ----------------------------------------------------------------------------
// plwu_search
// Landmark table and gated nearest-neighbor scan, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plwu_search
  import plwu_pkg::*;
#(
  parameter int unsigned MAX_LANDMARKS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire logic [5:0]         slot,
  input  wire lm_entry_t          entry,
  input  wire logic               go,
  input  wire logic signed [31:0] px,
  input  wire logic signed [31:0] py,
  input  wire logic signed [31:0] mx,
  input  wire logic signed [31:0] my,
  input  wire logic [30:0]        range_lim,
  input  wire logic [6:0]         count,
  output logic                    done,
  output plwu_match_t             match
);

  localparam int unsigned AW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int unsigned CW = $clog2(MAX_LANDMARKS + 1);

  lm_entry_t mem [MAX_LANDMARKS];
  lm_entry_t rd;

  logic [31:0]   slot_ext, count_ext;
  logic [CW-1:0] n_lim, idx;
  logic          running, active, v1, v2, v3;

  logic signed [32:0] gx, gy, dx, dy;
  logic [32:0]        gxa, gya, dxa, dya;
  logic               gate2, gate3;
  logic [31:0]        ax2, ay2;
  logic [15:0]        id2, id3;
  logic [63:0]        sa3, sb3;
  logic [64:0]        dist3, best_dist;
  logic               found;
  logic [15:0]        best_id;
  logic [63:0]        best_a, best_b;

  assign slot_ext  = 32'(slot);
  assign count_ext = 32'(count);
  assign n_lim     = (count_ext > MAX_LANDMARKS) ? CW'(MAX_LANDMARKS) : CW'(count_ext);

  always_ff @(posedge clk) begin
    if (load && slot_ext < MAX_LANDMARKS) begin
      mem[slot_ext[AW-1:0]] <= entry;
    end
    rd <= mem[idx[AW-1:0]];
  end

  always_comb begin
    gx  = {rd.x[31], rd.x} - {px[31], px};
    gy  = {rd.y[31], rd.y} - {py[31], py};
    dx  = {mx[31], mx} - {rd.x[31], rd.x};
    dy  = {my[31], my} - {rd.y[31], rd.y};
    gxa = gx[32] ? 33'(-gx) : 33'(gx);
    gya = gy[32] ? 33'(-gy) : 33'(gy);
    dxa = dx[32] ? 33'(-dx) : 33'(dx);
    dya = dy[32] ? 33'(-dy) : 33'(dy);
    dist3 = {1'b0, sa3} + {1'b0, sb3};
  end

  always_ff @(posedge clk) begin
    gate2 <= (gxa <= {2'b00, range_lim}) && (gya <= {2'b00, range_lim});
    ax2   <= dxa[31:0];
    ay2   <= dya[31:0];
    id2   <= rd.id;
    gate3 <= gate2;
    id3   <= id2;
    sa3   <= 64'(ax2) * 64'(ax2);
    sb3   <= 64'(ay2) * 64'(ay2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      active  <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      done    <= 1'b0;
      found   <= 1'b0;
      idx     <= '0;
    end else begin
      done <= 1'b0;
      v1   <= active;
      v2   <= v1;
      v3   <= v2;
      if (go) begin
        running <= 1'b1;
        active  <= (n_lim != '0);
        idx     <= '0;
        found   <= 1'b0;
      end else begin
        if (active) begin
          idx <= idx + 1'b1;
          if ((idx + 1'b1) == n_lim) begin
            active <= 1'b0;
          end
        end
        if (v3 && gate3 && (!found || dist3 < best_dist)) begin
          found <= 1'b1;
        end
        if (running && !active && !v1 && !v2 && !v3) begin
          done    <= 1'b1;
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && gate3 && (!found || dist3 < best_dist)) begin
      best_dist <= dist3;
      best_id   <= id3;
      best_a    <= sa3;
      best_b    <= sb3;
    end
  end

  assign match.found = found;
  assign match.id    = best_id;
  assign match.sqx   = best_a;
  assign match.sqy   = best_b;

endmodule

`default_nettype wire

@@ rtl/core/plwu_exp.sv @@
// ----------------------------------------------------------------------------
// plwu_exp
// Gaussian factor: exponent terms, range reduction, Horner series, scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module plwu_exp
  import plwu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [63:0] sqx,
  input  wire logic [63:0] sqy,
  input  wire logic [31:0] inv_x,
  input  wire logic [31:0] inv_y,
  input  wire logic [31:0] norm,
  output logic             done,
  output logic [31:0]      lik
);

  typedef enum logic [3:0] {
    S_IDLE, S_TERM, S_SUM, S_KMUL, S_KFIX, S_H1, S_H2, S_H3, S_FIN
  } state_t;

  state_t state;

  logic [55:0] hbx, lox, hby, loy;
  logic [30:0] e_q, tx, ty, p, pk;
  logic [31:0] e_sum, rem, q0, q;
  logic [39:0] kprod;
  logic [7:0]  k0;
  logic [6:0]  k;
  logic [29:0] r30;
  logic [60:0] m;
  logic [30:0] t;
  logic [63:0] pr, lprod;
  logic [3:0]  n;
  logic [34:0] chk;

  function automatic logic [30:0] term(input logic [55:0] hb, input logic [55:0] lo);
    logic [56:0] s;
    logic [40:0] v;
    s = 57'({hb[21:0], 24'b0}) + 57'(lo);
    v = s[56:16];
    if (hb[55:22] != '0) begin
      return EXP_CAP;
    end
    return (v > 41'(EXP_CAP)) ? EXP_CAP : v[30:0];
  endfunction

  always_comb begin
    tx    = term(hbx, lox);
    ty    = term(hby, loy);
    e_sum = 32'(tx) + 32'(ty);
    k0    = kprod[39:32];
    rem   = 32'(e_q) - 32'(k0) * 32'(LN2_Q24);
    q0    = pr[63:32];
    chk   = (35'(q0) + 35'd1) * 35'(n);
    q     = (chk <= 35'(t)) ? q0 + 32'd1 : q0;
    pk    = p >> k;
    lprod = 64'(norm) * 64'(pk);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (go) begin
            state <= S_TERM;
          end
        end
        S_TERM: state <= S_SUM;
        S_SUM:  state <= S_KMUL;
        S_KMUL: state <= S_KFIX;
        S_KFIX: begin
          if (rem >= 32'(LN2_Q24)) begin
            k   <= 7'(k0) + 7'd1;
            r30 <= {rem[23:0] - LN2_Q24, 6'b0};
          end else begin
            k   <= 7'(k0);
            r30 <= {rem[23:0], 6'b0};
          end
          p <= ONE_Q30;
          n <= 4'd8;
          if (k0 > 8'd30 || (k0 == 8'd30 && rem >= 32'(LN2_Q24))) begin
            lik   <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_H1;
          end
        end
        S_H1: state <= S_H2;
        S_H2: state <= S_H3;
        S_H3: begin
          p <= 31'(32'(ONE_Q30) - q);
          n <= n - 4'd1;
          state <= (n == 4'd1) ? S_FIN : S_H1;
        end
        S_FIN: begin
          lik   <= lprod[61:30];
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    hbx   <= 56'(sqx[63:40]) * 56'(inv_x);
    lox   <= 56'(sqx[39:16]) * 56'(inv_x);
    hby   <= 56'(sqy[63:40]) * 56'(inv_y);
    loy   <= 56'(sqy[39:16]) * 56'(inv_y);
    e_q   <= (e_sum > 32'(EXP_CAP)) ? EXP_CAP : e_sum[30:0];
    kprod <= 40'(e_q) * 40'(RECIP_LN2);
    m     <= 61'(r30) * 61'(p);
    t     <= m[60:30];
    pr    <= 64'(m[60:30]) * 64'(recip_n(n));
  end

endmodule

`default_nettype wire

@@ rtl/core/particle_landmark_weight_update.sv @@
// ----------------------------------------------------------------------------
// particle_landmark_weight_update
// Maps an observation, associates the nearest gated landmark and updates the
// running particle weight with the bivariate Gaussian factor.
// ----------------------------------------------------------------------------
// A load transaction (cmd 0) writes one table slot at the accepting edge and
// busy stays low. An observation (cmd 1) holds busy while it passes through the
// 16 CORDIC cells, the table scan at one landmark per cycle and, when a landmark
// passes the gate, 8 Horner steps (states S_H1, S_H2, S_H3) in the exponential
// unit. When the factor underflows to zero the series is skipped; with no
// landmark in range, or when no entry is searched, the exponential unit is not
// started. The result is registered and done is high for a single cycle; the
// receiver cannot stall it.
`default_nettype none

module particle_landmark_weight_update
  import plwu_pkg::*;
#(
  parameter int unsigned MAX_LANDMARKS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire plwu_in_t    in_data,
  output logic             done,
  output plwu_out_t        result,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [31:0] wr_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROT, S_PROD, S_MAP, S_SRCH, S_EXP, S_WGT
  } state_t;

  state_t state;

  logic [30:0] gate_range;
  logic [31:0] inv_two_var_x, inv_two_var_y, norm_factor, weight;
  logic [6:0]  landmark_count;

  plwu_in_t item;
  logic     accept, srch_go, exp_go, srch_done, exp_done;
  plwu_match_t match;
  logic [31:0] exp_lik, lik_q;
  logic        found_q;
  logic [15:0] id_q;

  logic                      cv [CORDIC_STAGES+1];
  logic signed [CW_BITS-1:0] cx [CORDIC_STAGES+1];
  logic signed [CW_BITS-1:0] cy [CORDIC_STAGES+1];
  logic signed [CW_BITS-1:0] cz [CORDIC_STAGES+1];

  logic signed [CW_BITS-1:0] c_q, s_q;
  logic signed [65:0]        p_cx, p_sy, p_sx, p_cy;
  logic signed [66:0]        sum_x, sum_y;
  logic signed [37:0]        tx, ty;
  logic signed [31:0]        mx, my, mx_sat, my_sat;
  logic [31:0]               w_base;
  logic [63:0]               w_prod;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign cv[0] = accept && (in_data.cmd == CMD_OBSERVE);
  assign cx[0] = CORDIC_K;
  assign cy[0] = '0;
  assign cz[0] = CW_BITS'({in_data.particle_heading[13:0], 16'b0});

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    plwu_cordic_cell #(.STAGE(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[g]),
      .in_x      (cx[g]),
      .in_y      (cy[g]),
      .in_z      (cz[g]),
      .out_valid (cv[g+1]),
      .out_x     (cx[g+1]),
      .out_y     (cy[g+1]),
      .out_z     (cz[g+1])
    );
  end

  plwu_search #(.MAX_LANDMARKS(MAX_LANDMARKS)) u_search (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && (in_data.cmd == CMD_LOAD)),
    .slot      (in_data.slot),
    .entry     ({in_data.landmark_id, in_data.landmark_x, in_data.landmark_y}),
    .go        (srch_go),
    .px        (item.particle_x),
    .py        (item.particle_y),
    .mx        (mx),
    .my        (my),
    .range_lim (gate_range),
    .count     (landmark_count),
    .done      (srch_done),
    .match     (match)
  );

  plwu_exp u_exp (
    .clk   (clk),
    .rst   (rst),
    .go    (exp_go),
    .sqx   (match.sqx),
    .sqy   (match.sqy),
    .inv_x (inv_two_var_x),
    .inv_y (inv_two_var_y),
    .norm  (norm_factor),
    .done  (exp_done),
    .lik   (exp_lik)
  );

  always_comb begin
    sum_x = {p_cx[65], p_cx} - {p_sy[65], p_sy} + 67'sd536870912;
    sum_y = {p_sx[65], p_sx} + {p_cy[65], p_cy} + 67'sd536870912;
    tx = {sum_x[66], sum_x[66:30]} + {{6{item.particle_x[31]}}, item.particle_x};
    ty = {sum_y[66], sum_y[66:30]} + {{6{item.particle_y[31]}}, item.particle_y};
    if (tx[37:31] == '0 || tx[37:31] == '1) begin
      mx_sat = tx[31:0];
    end else begin
      mx_sat = tx[37] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    if (ty[37:31] == '0 || ty[37:31] == '1) begin
      my_sat = ty[31:0];
    end else begin
      my_sat = ty[37] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    w_base = item.first_observation ? ONE_Q24 : weight;
    w_prod = 64'(w_base) * 64'(lik_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_range     <= 31'd3276800;
      inv_two_var_x  <= 32'd16777216;
      inv_two_var_y  <= 32'd16777216;
      norm_factor    <= 32'd2670177;
      landmark_count <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_GATE_RANGE:     gate_range     <= wr_data[30:0];
        REG_INV_TWO_VAR_X:  inv_two_var_x  <= wr_data;
        REG_INV_TWO_VAR_Y:  inv_two_var_y  <= wr_data;
        REG_NORM_FACTOR:    norm_factor    <= wr_data;
        REG_LANDMARK_COUNT: landmark_count <= wr_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      srch_go <= 1'b0;
      exp_go  <= 1'b0;
      weight  <= ONE_Q24;
    end else begin
      done    <= 1'b0;
      srch_go <= 1'b0;
      exp_go  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && in_data.cmd == CMD_OBSERVE) begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (cv[CORDIC_STAGES]) begin
            state <= S_PROD;
          end
        end
        S_PROD: state <= S_MAP;
        S_MAP: begin
          srch_go <= 1'b1;
          state   <= S_SRCH;
        end
        S_SRCH: begin
          if (srch_done) begin
            if (match.found) begin
              exp_go <= 1'b1;
              state  <= S_EXP;
            end else begin
              state <= S_WGT;
            end
          end
        end
        S_EXP: begin
          if (exp_done) begin
            state <= S_WGT;
          end
        end
        S_WGT: begin
          weight <= (w_prod[63:56] != '0) ? 32'hFFFFFFFF : w_prod[55:24];
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (state == S_ROT) begin
      case (item.particle_heading[15:14])
        2'd0: begin c_q <= cx[CORDIC_STAGES];  s_q <= cy[CORDIC_STAGES];  end
        2'd1: begin c_q <= -cy[CORDIC_STAGES]; s_q <= cx[CORDIC_STAGES];  end
        2'd2: begin c_q <= -cx[CORDIC_STAGES]; s_q <= -cy[CORDIC_STAGES]; end
        default: begin c_q <= cy[CORDIC_STAGES]; s_q <= -cx[CORDIC_STAGES]; end
      endcase
    end
    p_cx <= c_q * item.obs_x;
    p_sy <= s_q * item.obs_y;
    p_sx <= s_q * item.obs_x;
    p_cy <= c_q * item.obs_y;
    if (state == S_MAP) begin
      mx <= mx_sat;
      my <= my_sat;
    end
    if (state == S_SRCH && srch_done) begin
      found_q <= match.found;
      id_q    <= match.id;
      lik_q   <= '0;
    end
    if (state == S_EXP && exp_done) begin
      lik_q <= exp_lik;
    end
    if (state == S_WGT) begin
      result.map_x           <= mx;
      result.map_y           <= my;
      result.matched_id      <= found_q ? id_q : 16'd0;
      result.found           <= found_q;
      result.obs_likelihood  <= lik_q;
      result.particle_weight <= (w_prod[63:56] != '0) ? 32'hFFFFFFFF : w_prod[55:24];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/plwu_checker.sv @@
// ----------------------------------------------------------------------------
// plwu_checker
// Port-level checks of the landmark weight update block.
// ----------------------------------------------------------------------------
`default_nettype none

module plwu_checker
  import plwu_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire plwu_in_t  in_data,
  input wire logic      done,
  input wire plwu_out_t result
);

  a_obs_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && in_data.cmd == CMD_OBSERVE) |=> busy)
    else $error("observation transaction did not raise busy");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && in_data.cmd == CMD_LOAD) |=> (!busy && !done))
    else $error("load transaction produced activity");

  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result without a finished observation");

  a_no_match: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |->
      (result.matched_id == 16'd0 && result.obs_likelihood == 32'd0 &&
       result.particle_weight == 32'd0))
    else $error("unmatched observation with nonzero factor");

endmodule

bind particle_landmark_weight_update plwu_checker u_plwu_checker (.*);

`default_nettype wire
